@@ src/wfbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// wfbsm_pkg - shared types and constants of the buffer slot manager
// Operation and status codes, sequencer states and the store command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package wfbsm_pkg;

   localparam int SLOT_W          = 3;
   localparam int VALUE_W         = 32;
   localparam int DEF_SLOTS       = 5;
   localparam int DEF_MAX_HOLDERS = 15;

   localparam logic [VALUE_W-1:0] RESET_VALUE = 32'd99;

   typedef enum logic [1:0] {
      OP_ACQ_PREV = 2'd0,
      OP_ACQ_CUR  = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_PUBLISH  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_FREE     = 2'd1,
      ST_BAD_RELEASE = 2'd2,
      ST_OVERFLOW    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic cnt_inc;
      logic cnt_dec;
      logic val_we;
   } store_cmd_type;

endpackage

`default_nettype wire

@@ src/wait_free_buffer_slot_manager.sv @@
// ----------------------------------------------------------------------------
// wait_free_buffer_slot_manager - slot pool for one writer, many readers
//
// Request channel (req_): one word per operation - acquire previous, acquire
// current, release a slot, publish a value. Response channel (rsp_): one word
// per request with slot, value, status and the current/previous indices.
// Both channels: a word moves when valid is high and stall is low.
//
// Acquire and release run in one access step. A publish walks the pool one
// slot per cycle through a single count compare, up to the first free slot.
// One operation is in flight at a time; the next request is taken once the
// previous response sits in the output register.
//
// Reset: slot 0 holds 99, all other values and all holder counts are zero,
// current and previous are slot 0. While rsp_stall is high the response
// holds in the output register; one further operation may complete and then
// waits until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module wait_free_buffer_slot_manager #(
   parameter int SLOTS       = wfbsm_pkg::DEF_SLOTS,
   parameter int MAX_HOLDERS = wfbsm_pkg::DEF_MAX_HOLDERS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_operation,
   input  wire logic [2:0]                          req_slot_in,
   input  wire logic signed [31:0]                  req_value_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [2:0]                               rsp_slot_out,
   output logic signed [31:0]                       rsp_value_out,
   output logic [1:0]                               rsp_status,
   output logic [2:0]                               rsp_current_slot,
   output logic [2:0]                               rsp_previous_slot
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(MAX_HOLDERS+1);

   logic                              out_free;
   logic                              res_valid;
   logic [wfbsm_pkg::SLOT_W-1:0]      res_slot;
   logic [wfbsm_pkg::VALUE_W-1:0]     res_value;
   wfbsm_pkg::status_type             res_status;
   logic [IDX_W-1:0]                  cur_idx;
   logic [IDX_W-1:0]                  prev_idx;
   logic [IDX_W-1:0]                  st_idx;
   wfbsm_pkg::store_cmd_type          st_cmd;
   logic [wfbsm_pkg::VALUE_W-1:0]     st_wdata;
   logic [CNT_W-1:0]                  st_rd_count;
   logic [wfbsm_pkg::VALUE_W-1:0]     st_rd_value;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [2:0]                        slot_out_ff;
   logic [31:0]                       value_out_ff;
   logic [1:0]                        status_ff;
   logic [2:0]                        current_ff;
   logic [2:0]                        previous_ff;

   wfbsm_seq #(
      .SLOTS       (SLOTS),
      .MAX_HOLDERS (MAX_HOLDERS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_slot_in   (req_slot_in),
      .req_value_in  (req_value_in),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res_slot      (res_slot),
      .res_value     (res_value),
      .res_status    (res_status),
      .cur_idx       (cur_idx),
      .prev_idx      (prev_idx),
      .st_idx        (st_idx),
      .st_cmd        (st_cmd),
      .st_wdata      (st_wdata),
      .st_rd_count   (st_rd_count),
      .st_rd_value   (st_rd_value)
   );

   wfbsm_store #(
      .SLOTS       (SLOTS),
      .MAX_HOLDERS (MAX_HOLDERS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .idx      (st_idx),
      .cmd      (st_cmd),
      .wdata    (st_wdata),
      .rd_count (st_rd_count),
      .rd_value (st_rd_value)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         slot_out_ff  <= res_slot;
         value_out_ff <= res_value;
         status_ff    <= res_status;
         current_ff   <= wfbsm_pkg::SLOT_W'(cur_idx);
         previous_ff  <= wfbsm_pkg::SLOT_W'(prev_idx);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_out      = slot_out_ff;
   assign rsp_value_out     = value_out_ff;
   assign rsp_status        = status_ff;
   assign rsp_current_slot  = current_ff;
   assign rsp_previous_slot = previous_ff;

endmodule

`default_nettype wire

@@ src/wfbsm_store.sv @@
// ----------------------------------------------------------------------------
// wfbsm_store - slot value and holder count storage
// One read index, count increment/decrement and value write at that index.
// ----------------------------------------------------------------------------
`default_nettype none

module wfbsm_store #(
   parameter int SLOTS       = wfbsm_pkg::DEF_SLOTS,
   parameter int MAX_HOLDERS = wfbsm_pkg::DEF_MAX_HOLDERS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [$clog2(SLOTS)-1:0]            idx,
   input  wire wfbsm_pkg::store_cmd_type            cmd,
   input  wire logic [wfbsm_pkg::VALUE_W-1:0]       wdata,
   output logic [$clog2(MAX_HOLDERS+1)-1:0]         rd_count,
   output logic [wfbsm_pkg::VALUE_W-1:0]            rd_value
);

   localparam int CNT_W = $clog2(MAX_HOLDERS+1);

   logic [CNT_W-1:0]              counts_ff [SLOTS];
   logic [CNT_W-1:0]              counts_in [SLOTS];
   logic [wfbsm_pkg::VALUE_W-1:0] values_ff [SLOTS];
   logic [wfbsm_pkg::VALUE_W-1:0] values_in [SLOTS];
   logic                          idx_ok;

   assign idx_ok = int'(idx) < SLOTS;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         counts_in[i] = counts_ff[i];
         values_in[i] = values_ff[i];
         if (idx_ok && int'(idx) == i) begin
            if (cmd.cnt_inc) begin
               counts_in[i] = counts_ff[i] + 1'b1;
            end else if (cmd.cnt_dec) begin
               counts_in[i] = counts_ff[i] - 1'b1;
            end
            if (cmd.val_we) begin
               values_in[i] = wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            counts_ff[i] <= '0;
            values_ff[i] <= (i == 0) ? wfbsm_pkg::RESET_VALUE : '0;
         end
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            counts_ff[i] <= counts_in[i];
            values_ff[i] <= values_in[i];
         end
      end
   end

   assign rd_count = idx_ok ? counts_ff[idx] : '0;
   assign rd_value = idx_ok ? values_ff[idx] : '0;

endmodule

`default_nettype wire

@@ src/wfbsm_seq.sv @@
// ----------------------------------------------------------------------------
// wfbsm_seq - operation sequencer
// Runs acquire and release in one access step and walks the pool one slot
// a cycle through the shared count compare for a publish.
// ----------------------------------------------------------------------------
`default_nettype none

module wfbsm_seq #(
   parameter int SLOTS       = wfbsm_pkg::DEF_SLOTS,
   parameter int MAX_HOLDERS = wfbsm_pkg::DEF_MAX_HOLDERS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_operation,
   input  wire logic [wfbsm_pkg::SLOT_W-1:0]        req_slot_in,
   input  wire logic [wfbsm_pkg::VALUE_W-1:0]       req_value_in,
   input  wire logic                                out_free,
   output logic                                     res_valid,
   output logic [wfbsm_pkg::SLOT_W-1:0]             res_slot,
   output logic [wfbsm_pkg::VALUE_W-1:0]            res_value,
   output wfbsm_pkg::status_type                    res_status,
   output logic [$clog2(SLOTS)-1:0]                 cur_idx,
   output logic [$clog2(SLOTS)-1:0]                 prev_idx,
   output logic [$clog2(SLOTS)-1:0]                 st_idx,
   output wfbsm_pkg::store_cmd_type                 st_cmd,
   output logic [wfbsm_pkg::VALUE_W-1:0]            st_wdata,
   input  wire logic [$clog2(MAX_HOLDERS+1)-1:0]    st_rd_count,
   input  wire logic [wfbsm_pkg::VALUE_W-1:0]       st_rd_value
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(MAX_HOLDERS+1);
   localparam int SCAN_W = $clog2(SLOTS+1);
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOTS-1);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SLOTS-1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_HOLDERS);

   wfbsm_pkg::state_type             state_ff, state_in;
   wfbsm_pkg::op_type                op_ff, op_in;
   logic [wfbsm_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [wfbsm_pkg::VALUE_W-1:0]    value_ff, value_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [IDX_W-1:0]                 cur_ff, cur_in;
   logic [IDX_W-1:0]                 prev_ff, prev_in;
   logic [SCAN_W-1:0]                scan_ff, scan_in;
   logic [wfbsm_pkg::SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [wfbsm_pkg::VALUE_W-1:0]    res_value_ff, res_value_in;
   wfbsm_pkg::status_type            res_status_ff, res_status_in;

   logic accept;
   logic cnt_zero;
   logic cnt_full;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   assign accept   = req_valid && (state_ff == wfbsm_pkg::S_IDLE);
   assign req_stall = reset || (state_ff != wfbsm_pkg::S_IDLE);

   // shared count compare
   assign cnt_zero = st_rd_count == '0;
   assign cnt_full = st_rd_count >= CNT_MAX;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wfbsm_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (wfbsm_pkg::op_type'(req_operation) == wfbsm_pkg::OP_PUBLISH)
                          ? wfbsm_pkg::S_SCAN : wfbsm_pkg::S_ACCESS;
            end
         end
         wfbsm_pkg::S_ACCESS: begin
            state_in = wfbsm_pkg::S_DONE;
         end
         wfbsm_pkg::S_SCAN: begin
            if (cnt_zero || scan_ff == SCAN_LAST) begin
               state_in = wfbsm_pkg::S_DONE;
            end
         end
         wfbsm_pkg::S_DONE: begin
            if (out_free) begin
               state_in = wfbsm_pkg::S_IDLE;
            end
         end
         default: state_in = wfbsm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      slot_in       = slot_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      scan_in       = scan_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      st_cmd        = '0;
      unique case (state_ff)
         wfbsm_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = wfbsm_pkg::op_type'(req_operation);
               slot_in  = req_slot_in;
               value_in = req_value_in;
               scan_in  = '0;
               unique case (wfbsm_pkg::op_type'(req_operation))
                  wfbsm_pkg::OP_ACQ_PREV: idx_in = prev_ff;
                  wfbsm_pkg::OP_ACQ_CUR:  idx_in = cur_ff;
                  wfbsm_pkg::OP_RELEASE:  idx_in = req_slot_in[IDX_W-1:0];
                  wfbsm_pkg::OP_PUBLISH: begin
                     idx_in  = next_idx(cur_ff);
                     prev_in = cur_ff;
                  end
                  default: idx_in = cur_ff;
               endcase
            end
         end
         wfbsm_pkg::S_ACCESS: begin
            if (op_ff == wfbsm_pkg::OP_RELEASE) begin
               res_slot_in = slot_ff;
               if (int'(slot_ff) >= SLOTS) begin
                  res_status_in = wfbsm_pkg::ST_BAD_RELEASE;
                  res_value_in  = '0;
               end else if (cnt_zero) begin
                  res_status_in = wfbsm_pkg::ST_BAD_RELEASE;
                  res_value_in  = st_rd_value;
               end else begin
                  st_cmd.cnt_dec = 1'b1;
                  res_status_in  = wfbsm_pkg::ST_OK;
                  res_value_in   = st_rd_value;
               end
            end else begin
               res_slot_in  = wfbsm_pkg::SLOT_W'(idx_ff);
               res_value_in = st_rd_value;
               if (cnt_full) begin
                  res_status_in = wfbsm_pkg::ST_OVERFLOW;
               end else begin
                  st_cmd.cnt_inc = 1'b1;
                  res_status_in  = wfbsm_pkg::ST_OK;
               end
            end
         end
         wfbsm_pkg::S_SCAN: begin
            if (cnt_zero) begin
               st_cmd.val_we = 1'b1;
               cur_in        = idx_ff;
               res_slot_in   = wfbsm_pkg::SLOT_W'(idx_ff);
               res_value_in  = value_ff;
               res_status_in = wfbsm_pkg::ST_OK;
            end else if (scan_ff == SCAN_LAST) begin
               // last slot tried is the current one
               res_slot_in   = wfbsm_pkg::SLOT_W'(cur_ff);
               res_value_in  = st_rd_value;
               res_status_in = wfbsm_pkg::ST_NO_FREE;
            end else begin
               idx_in  = next_idx(idx_ff);
               scan_in = scan_ff + 1'b1;
            end
         end
         wfbsm_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wfbsm_pkg::S_IDLE;
         cur_ff   <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   assign st_idx     = idx_ff;
   assign st_wdata   = value_ff;
   assign res_valid  = (state_ff == wfbsm_pkg::S_DONE) && out_free;
   assign res_slot   = res_slot_ff;
   assign res_value  = res_value_ff;
   assign res_status = res_status_ff;
   assign cur_idx    = cur_ff;
   assign prev_idx   = prev_ff;

   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      int'(cur_ff) < SLOTS)
      else $error("current index out of range");

   a_prev_range: assert property (@(posedge clock) disable iff (reset)
      int'(prev_ff) < SLOTS)
      else $error("previous index out of range");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wfbsm_pkg::S_SCAN) |-> (int'(scan_ff) < SLOTS))
      else $error("publish scan ran past the pool");

   a_pick_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wfbsm_pkg::S_SCAN && cnt_zero) |=> (cur_ff == $past(idx_ff)))
      else $error("free slot not made current");

endmodule

`default_nettype wire

@@ test/wfbsm_checker.sv @@
// ----------------------------------------------------------------------------
// wfbsm_checker - response checker for the buffer slot manager
// Watches both channels and keeps its own copy of the slot pool. Each request
// word taken by the block is turned into the expected response and queued.
// Each response word taken from the block is compared field by field with the
// oldest entry in the queue. The failure count and the number of responses
// still owed are handed to the testbench top.
// ----------------------------------------------------------------------------

module wfbsm_checker
   import wfbsm_pkg::*;
#(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int MAX_HOLDERS = DEF_MAX_HOLDERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [2:0]         req_slot_in,
   input  logic signed [31:0] req_value_in,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_slot_out,
   input  logic signed [31:0] rsp_value_out,
   input  logic [1:0]         rsp_status,
   input  logic [2:0]         rsp_current_slot,
   input  logic [2:0]         rsp_previous_slot,
   output int                 errors,
   output int                 outstanding
);

   typedef struct {
      logic [2:0]         slot;
      logic signed [31:0] value;
      status_type         status;
      logic [2:0]         current;
      logic [2:0]         previous;
   } slot_reply_type;

   logic signed [31:0] slot_value [SLOTS];
   int                 holder_count [SLOTS];
   int                 cur_slot;
   int                 prev_slot;
   slot_reply_type     expected_replies [$];

   task automatic clear_pool();
      for (int i = 0; i < SLOTS; i++) begin
         slot_value[i]   = '0;
         holder_count[i] = 0;
      end
      slot_value[0] = RESET_VALUE;
      cur_slot      = 0;
      prev_slot     = 0;
   endtask

   // one operation applied to the pool copy; returns the response it yields
   function automatic slot_reply_type apply_slot_op(op_type op, logic [2:0] sl,
                                                    logic signed [31:0] vi);
      slot_reply_type r;
      int             idx;
      int             cand;
      int             pick;
      bit             found;
      r.slot   = '0;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
         OP_ACQ_PREV, OP_ACQ_CUR: begin
            idx     = (op == OP_ACQ_PREV) ? prev_slot : cur_slot;
            r.slot  = 3'(idx);
            r.value = slot_value[idx];
            if (holder_count[idx] >= MAX_HOLDERS) begin
               r.status = ST_OVERFLOW;
            end else begin
               holder_count[idx]++;
            end
         end
         OP_RELEASE: begin
            r.slot = sl;
            if (sl >= SLOTS) begin
               r.status = ST_BAD_RELEASE;
            end else if (holder_count[sl] == 0) begin
               r.status = ST_BAD_RELEASE;
               r.value  = slot_value[sl];
            end else begin
               holder_count[sl]--;
               r.value = slot_value[sl];
            end
         end
         default: begin
            prev_slot = cur_slot;
            found     = 1'b0;
            pick      = 0;
            // circular search, the current slot is tried last
            for (int k = 1; k <= SLOTS; k++) begin
               cand = (cur_slot + k) % SLOTS;
               if (!found && holder_count[cand] == 0) begin
                  found = 1'b1;
                  pick  = cand;
               end
            end
            if (found) begin
               cur_slot         = pick;
               slot_value[pick] = vi;
            end else begin
               r.status = ST_NO_FREE;
            end
            r.slot  = 3'(cur_slot);
            r.value = slot_value[cur_slot];
         end
      endcase
      r.current  = 3'(cur_slot);
      r.previous = 3'(prev_slot);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         if (errors < 10) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
         end
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      slot_reply_type want;
      if (reset) begin
         clear_pool();
         expected_replies.delete();
         errors = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: response word with nothing pending", $realtime);
               end
               errors++;
            end else begin
               want = expected_replies.pop_front();
               check_field("slot_out", want.slot, rsp_slot_out);
               check_field("value_out", want.value, rsp_value_out);
               check_field("status", want.status, rsp_status);
               check_field("current_slot", want.current, rsp_current_slot);
               check_field("previous_slot", want.previous, rsp_previous_slot);
            end
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_slot_op(op_type'(req_operation),
                                                     req_slot_in, req_value_in));
         end
      end
      outstanding = expected_replies.size();
   end

endmodule

@@ test/tb_wait_free_buffer_slot_manager.sv @@
// ----------------------------------------------------------------------------
// tb_wait_free_buffer_slot_manager - testbench top for the buffer slot manager
// Drives request words (a directed opening, then random phases built from
// acquire bursts, release sweeps and single operations), stalls the response
// channel at random and twice for a long stretch, and gives the verdict from
// the checker's failure count. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------

module tb_wait_free_buffer_slot_manager;
   import wfbsm_pkg::*;

   localparam int SLOTS        = DEF_SLOTS;
   localparam int MAX_HOLDERS  = DEF_MAX_HOLDERS;
   localparam int LONG_HOLD    = 400;
   localparam int STUCK_LIMIT  = 5000;
   localparam int PHASE_WORDS  = 645;

   logic               clock;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = OP_ACQ_PREV;
   logic [2:0]         req_slot_in   = '0;
   logic signed [31:0] req_value_in  = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic [2:0]         rsp_slot_out;
   logic signed [31:0] rsp_value_out;
   logic [1:0]         rsp_status;
   logic [2:0]         rsp_current_slot;
   logic [2:0]         rsp_previous_slot;

   int          mismatches;
   int          pending_replies;
   int          words_sent     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned holds_asked    = 0;
   int          stuck_cycles   = 0;

   wait_free_buffer_slot_manager #(
      .SLOTS       (SLOTS),
      .MAX_HOLDERS (MAX_HOLDERS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_slot_in       (req_slot_in),
      .req_value_in      (req_value_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_status        (rsp_status),
      .rsp_current_slot  (rsp_current_slot),
      .rsp_previous_slot (rsp_previous_slot)
   );

   wfbsm_checker #(
      .SLOTS       (SLOTS),
      .MAX_HOLDERS (MAX_HOLDERS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_slot_in       (req_slot_in),
      .req_value_in      (req_value_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_status        (rsp_status),
      .rsp_current_slot  (rsp_current_slot),
      .rsp_previous_slot (rsp_previous_slot),
      .errors            (mismatches),
      .outstanding       (pending_replies)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random stall, or a long hold-off when one is asked for
   initial begin : receiver
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served != holds_asked) begin
            hold_left = LONG_HOLD;
            holds_served++;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_word(op_type op, logic [2:0] slot, logic signed [31:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_slot_in   <= slot;
      req_value_in  <= value;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_replies != 0);
      @(posedge clock);
   endtask

   function automatic logic [2:0] any_slot();
      if ($urandom_range(0, 7) == 0) begin
         return 3'($urandom_range(SLOTS, 7));
      end
      return 3'($urandom_range(0, SLOTS - 1));
   endfunction

   task automatic send_random_op();
      int    pick;
      op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         op = OP_ACQ_PREV;
      end else if (pick < 36) begin
         op = OP_ACQ_CUR;
      end else if (pick < 70) begin
         op = OP_RELEASE;
      end else begin
         op = OP_PUBLISH;
      end
      send_word(op, any_slot(), $urandom);
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int count, bit with_hold);
      int     stop_at;
      int     pick;
      int     n;
      op_type op;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (with_hold) begin
         holds_asked++;
      end
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // burst of acquires, most long enough to run a holder count to its limit
            n  = $urandom_range(14, 20);
            op = ($urandom_range(0, 3) == 0) ? OP_ACQ_PREV : OP_ACQ_CUR;
            repeat (n) send_word(op, any_slot(), $urandom);
         end else if (pick < 24) begin
            for (int s = 0; s < SLOTS; s++) begin
               n = $urandom_range(1, 4);
               repeat (n) send_word(OP_RELEASE, 3'(s), $urandom);
            end
         end else if (pick < 26) begin
            wait_for_responses();
         end else begin
            send_random_op();
         end
      end
      wait_for_responses();
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 10;
      recv_stall_pct = 10;
      send_word(OP_ACQ_PREV, 3'd0, 32'sd0);
      send_word(OP_RELEASE, 3'd0, -32'sd1);
      send_word(OP_RELEASE, 3'd0, 32'sd0);   // nobody holds it
      send_word(OP_RELEASE, 3'(SLOTS), 32'sd0);
      send_word(OP_RELEASE, 3'd7, 32'sd0);
      send_word(OP_PUBLISH, 3'd7, 32'h7fffffff);
      send_word(OP_PUBLISH, 3'd0, 32'h80000000);
      send_word(OP_PUBLISH, 3'd5, 32'h00000000);
      send_word(OP_PUBLISH, 3'd2, 32'hffffffff);
      send_word(OP_PUBLISH, 3'd1, $urandom);  // wraps round to slot 0
      send_word(OP_ACQ_PREV, 3'd6, $urandom);
      // pin every slot so that a publish finds none free
      repeat (4) begin
         send_word(OP_ACQ_CUR, 3'd3, $urandom);
         send_word(OP_PUBLISH, 3'd4, $urandom);
      end
      send_word(OP_PUBLISH, 3'd0, $urandom);
      for (int s = 0; s < SLOTS; s++) begin
         send_word(OP_RELEASE, 3'(s), $urandom);
      end
      wait_for_responses();

      run_phase(38, 79, PHASE_WORDS, 1'b1);
      run_phase(79, 38, PHASE_WORDS, 1'b0);
      run_phase(0, 0, PHASE_WORDS, 1'b1);

      repeat (SLOTS + 8) @(posedge clock);
      if (mismatches == 0 && pending_replies == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/wfbsm_pkg.sv
src/wfbsm_store.sv
src/wfbsm_seq.sv
src/wait_free_buffer_slot_manager.sv
test/wfbsm_checker.sv
test/tb_wait_free_buffer_slot_manager.sv
